// ===== rtl/upd_pkg.sv =====
// Package for the URL percent decoder: widths, character codes, result struct
// and the hex-digit and mode-mapping functions.
// No dependencies; every other file of the block uses it.
`default_nettype none

package upd_pkg;

    localparam int CHAR_W    = 8;
    localparam int NIBBLE_W  = 4;

    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'd37;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UC_A    = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UC_F    = 8'd70;
    localparam logic [CHAR_W-1:0] CH_LC_A    = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LC_F    = 8'd102;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;

    // Decode step result handed from the decoder to the output register.
    typedef struct packed {
        logic              emit;
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
    } t_upd_res;

    // Value of a hex digit; anything that is not a digit counts as zero.
    function automatic logic [NIBBLE_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = CH_NUL;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d = c - CH_UC_A + 8'd10;
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d = c - CH_LC_A + 8'd10;
        end
        return d[NIBBLE_W-1:0];
    endfunction

    // Form mode turns decoded CR and LF into space; keep-plus mode turns
    // decoded CR, LF and space into a plus sign.
    function automatic logic [CHAR_W-1:0] map_decoded(input logic plus_mode,
                                                      input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] m;
        m = b;
        if (!plus_mode) begin
            if (b == CH_LF || b == CH_CR) begin
                m = CH_SPACE;
            end
        end else begin
            if (b == CH_LF || b == CH_CR || b == CH_SPACE) begin
                m = CH_PLUS;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/upd_if.sv =====
// Handshake channels of the URL percent decoder: encoded characters in,
// decoded characters out. Depends on upd_pkg for the character width.
`default_nettype none

interface upd_in_if;
    logic                       valid;
    logic                       ready;
    logic [upd_pkg::CHAR_W-1:0] in_char;
    logic                       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface upd_out_if;
    logic                       valid;
    logic                       ready;
    logic [upd_pkg::CHAR_W-1:0] out_char;
    logic                       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/upd_decode.sv =====
// Escape tracking and character decoding for one word per cycle while i_advance is high.
// Depends on upd_pkg for codes, the result struct and the helper functions.
`default_nettype none

module upd_decode (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic [upd_pkg::CHAR_W-1:0] i_char,
    input  wire logic                       i_last,
    input  wire logic                       i_plus_mode,
    output upd_pkg::t_upd_res               o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } t_phase;

    t_phase                       r_phase;
    t_phase                       n_phase;
    logic [upd_pkg::NIBBLE_W-1:0] r_nibble;
    logic [upd_pkg::NIBBLE_W-1:0] n_nibble;
    logic [upd_pkg::NIBBLE_W-1:0] digit;

    assign digit = upd_pkg::hex_value(i_char);

    always_comb begin
        o_res          = '0;
        o_res.out_last = i_last;
        n_phase        = PH_IDLE;
        n_nibble       = '0;
        unique case (r_phase)
            PH_HIGH: begin
                if (i_last) begin
                    // The low digit is missing, so it counts as zero.
                    o_res.emit     = 1'b1;
                    o_res.out_char = upd_pkg::map_decoded(i_plus_mode,
                                                          {digit, 4'b0000});
                end else begin
                    n_phase  = PH_LOW;
                    n_nibble = digit;
                end
            end
            PH_LOW: begin
                o_res.emit     = 1'b1;
                o_res.out_char = upd_pkg::map_decoded(i_plus_mode, {r_nibble, digit});
            end
            default: begin
                if (i_char == upd_pkg::CH_PERCENT) begin
                    if (i_last) begin
                        o_res.emit     = 1'b1;
                        o_res.out_char = upd_pkg::map_decoded(i_plus_mode,
                                                              upd_pkg::CH_NUL);
                    end else begin
                        n_phase = PH_HIGH;
                    end
                end else begin
                    o_res.emit = 1'b1;
                    if (i_char == upd_pkg::CH_PLUS) begin
                        o_res.out_char = i_plus_mode ? upd_pkg::CH_PLUS
                                                     : upd_pkg::CH_SPACE;
                    end else begin
                        o_res.out_char = i_char;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_nibble <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_nibble <= n_nibble;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/url_percent_decoder.sv =====
// URL percent decoder top level: input register, decoder, output register.
// Depends on upd_pkg, upd_in_if, upd_out_if and upd_decode.
//
// Usage: encoded characters arrive one word per handshake on i_in, with
// in_last marking the end of a string; decoded characters leave on o_out.
// A '%' and the high digit of an escape produce no word, unless in_last
// cuts the escape short, in which case the missing digits count as zero.
// i_cfg_we with i_cfg_wdata sets the plus mode (0 form, 1 keep-plus); write
// it only while no word is in flight.
// Path: an accepted word is held in the input register, is decoded there
// and, if it yields a word, lands in the output register, from which o_out
// takes it. Throughput is one word per cycle while o_out.ready stays high,
// set by the single decode step between the two registers.
// Reset (synchronous, active low) empties both registers, returns the
// escape tracking to idle and clears the plus mode to form mode.
// When the receiver stalls, the output register holds its word; the input
// register takes one more word, and words that produce no output still
// pass through. Then i_in.ready drops until o_out.ready returns.
`default_nettype none

module url_percent_decoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    upd_in_if.sink    i_in,
    upd_out_if.source o_out,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata
);

    logic                       r_in_valid;
    logic [upd_pkg::CHAR_W-1:0] r_in_char;
    logic                       r_in_last;
    logic                       r_out_valid;
    logic [upd_pkg::CHAR_W-1:0] r_out_char;
    logic                       r_out_last;
    logic                       r_plus_mode;
    logic                       advance;
    upd_pkg::t_upd_res          res;

    upd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_plus_mode (r_plus_mode),
        .o_res       (res)
    );

    // A word that yields no output may move on even while the output stalls.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready || !res.emit);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.in_char;
            r_in_last <= i_in.in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && res.emit) begin
            r_out_char <= res.out_char;
            r_out_last <= res.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_plus_mode <= i_cfg_wdata;
        end
    end

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output word valid after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input refused while input register is empty");

    a_silent_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !res.emit && r_out_valid && !o_out.ready)
        |=> (o_out.valid && $stable(o_out.out_char) && $stable(o_out.out_last)))
        else $error("stalled output word changed by a word that yields nothing");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for url_percent_decoder: drives encoded characters,
// predicts every decoded word and checks the output stream against it.
// Depends on upd_pkg and the upd_in_if / upd_out_if channel interfaces.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 7;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          TAIL_CYCLES  = 10;
    localparam int          PHASE_ITEMS  = 105;
    localparam int          HOLD_CYCLES  = 80;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef logic [upd_pkg::CHAR_W-1:0]   char_t;
    typedef logic [upd_pkg::NIBBLE_W-1:0] nibble_t;

    // Predicts the decoded stream and keeps the words still owed by the block.
    class decode_scoreboard;
        typedef enum logic [1:0] {ESC_IDLE, ESC_HIGH, ESC_LOW} esc_e;
        typedef struct packed {
            char_t ch;
            logic  last;
        } word_t;

        bit          plus_mode;
        esc_e        esc;
        nibble_t     high_digit;
        word_t       owed_words[$];
        int unsigned errors;

        function new();
            plus_mode  = 1'b0;
            esc        = ESC_IDLE;
            high_digit = '0;
            errors     = 0;
        endfunction

        function nibble_t digit_of(char_t c);
            if (c inside {[upd_pkg::CH_ZERO:upd_pkg::CH_NINE]}) begin
                return c[3:0];
            end
            // 'A'..'F' and 'a'..'f' both carry 1..6 in their low nibble.
            if (c inside {[upd_pkg::CH_UC_A:upd_pkg::CH_UC_F],
                          [upd_pkg::CH_LC_A:upd_pkg::CH_LC_F]}) begin
                return c[3:0] + nibble_t'(9);
            end
            return '0;
        endfunction

        function char_t fold_special(char_t b);
            if (b == upd_pkg::CH_LF || b == upd_pkg::CH_CR ||
                (plus_mode && b == upd_pkg::CH_SPACE)) begin
                return plus_mode ? upd_pkg::CH_PLUS : upd_pkg::CH_SPACE;
            end
            return b;
        endfunction

        function int unsigned owed();
            return owed_words.size();
        endfunction

        function void predict_word(char_t c, logic last);
            word_t w;
            bit    emit;
            emit   = 1'b1;
            w.last = last;
            w.ch   = c;
            case (esc)
                ESC_HIGH: begin
                    high_digit = digit_of(c);
                    if (last) begin
                        w.ch = fold_special({high_digit, 4'h0});
                        esc  = ESC_IDLE;
                    end else begin
                        emit = 1'b0;
                        esc  = ESC_LOW;
                    end
                end
                ESC_LOW: begin
                    w.ch = fold_special({high_digit, digit_of(c)});
                    esc  = ESC_IDLE;
                end
                default: begin
                    esc = ESC_IDLE;
                    if (c == upd_pkg::CH_PERCENT) begin
                        if (last) begin
                            w.ch = fold_special(upd_pkg::CH_NUL);
                        end else begin
                            emit = 1'b0;
                            esc  = ESC_HIGH;
                        end
                    end else if (c == upd_pkg::CH_PLUS) begin
                        w.ch = plus_mode ? upd_pkg::CH_PLUS : upd_pkg::CH_SPACE;
                    end
                end
            endcase
            if (emit) begin
                owed_words.push_back(w);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_word(char_t c, logic last);
            word_t w;
            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("word 0x%02h last %0b with nothing owed", c, last));
            end else begin
                w = owed_words.pop_front();
                if (c !== w.ch) begin
                    report_mismatch($sformatf("out_char 0x%02h, predicted 0x%02h", c, w.ch));
                end
                if (last !== w.last) begin
                    report_mismatch($sformatf("out_last %0b, predicted %0b", last, w.last));
                end
            end
        endtask

        task check_leftover();
            if (owed_words.size() != 0) begin
                report_mismatch($sformatf("%0d words never arrived", owed_words.size()));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    upd_in_if  in_ch ();
    upd_out_if out_ch ();

    url_percent_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    decode_scoreboard sb = new();

    bit          calm      = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_cnt = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiving side: takes words, stalls at random and honours a long hold-off.
    initial begin : out_side
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_word(out_ch.out_char, out_ch.out_last);
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 26);
            end
        end
    end

    function automatic char_t hex_char(nibble_t n);
        if (n < 10) begin
            return upd_pkg::CH_ZERO + char_t'(n);
        end
        return ($urandom_range(1) ? upd_pkg::CH_LC_A : upd_pkg::CH_UC_A) + char_t'(n - 10);
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic drive_word(char_t c, logic last);
        while (!calm && $urandom_range(99) < 26) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_char <= c;
        in_ch.in_last <= last;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        sb.predict_word(c, last);
    endtask

    task automatic send_string(string s);
        for (int k = 0; k < s.len(); k++) begin
            drive_word(char_t'(s[k]), k == s.len() - 1);
        end
    endtask

    // Stops offering until every owed word is out and the pipeline is empty.
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (sb.owed() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(bit m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.plus_mode = m;
    endtask

    // Mostly well-formed escapes with random content, with literal text,
    // raw bytes, malformed escapes and strings cut off inside an escape.
    task automatic run_random_phase(int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        char_t       code;
        char_t       text[$];
        sent = 0;
        while (sent < n_items) begin
            text.delete();
            repeat ($urandom_range(1, 8)) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    case ($urandom_range(4))
                        0:       code = upd_pkg::CH_LF;
                        1:       code = upd_pkg::CH_CR;
                        2:       code = upd_pkg::CH_SPACE;
                        default: code = char_t'($urandom_range(255));
                    endcase
                    text.push_back(upd_pkg::CH_PERCENT);
                    text.push_back(hex_char(code[7:4]));
                    text.push_back(hex_char(code[3:0]));
                end else if (pick < 65) begin
                    text.push_back(upd_pkg::CH_PLUS);
                end else if (pick < 75) begin
                    text.push_back(char_t'($urandom_range(32, 126)));
                end else if (pick < 88) begin
                    text.push_back(char_t'($urandom_range(255)));
                end else begin
                    text.push_back(upd_pkg::CH_PERCENT);
                    text.push_back($urandom_range(1) ? upd_pkg::CH_PERCENT
                                                     : upd_pkg::CH_PLUS);
                    text.push_back(char_t'($urandom_range(255)));
                end
            end
            case ($urandom_range(9))
                0: text.push_back(upd_pkg::CH_PERCENT);
                1: begin
                    text.push_back(upd_pkg::CH_PERCENT);
                    text.push_back(hex_char(nibble_t'($urandom_range(15))));
                end
                default: ;
            endcase
            foreach (text[k]) begin
                drive_word(text[k], k == text.size() - 1);
            end
            sent += text.size();
        end
    endtask

    initial begin : in_side
        in_ch.valid   <= 1'b0;
        in_ch.in_char <= upd_pkg::CH_NUL;
        in_ch.in_last <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Form mode: plus to space, decoded CR/LF to space, truncated escapes.
        set_mode(1'b0);
        send_string("+%0a%0D");
        send_string("%");
        send_string("%f");
        send_string("%%+");
        drive_word(upd_pkg::CH_NUL, 1'b0);
        drive_word(8'hFF, 1'b1);
        wait_drain();

        // Keep-plus mode: plus stays plus, decoded space and LF become plus, truncated escapes.
        set_mode(1'b1);
        send_string("+%20%0A");
        send_string("%2");
        send_string("%");
        wait_drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_mode(ph[0] ? 1'b0 : 1'b1);
            calm = (ph == 2);
            if (ph == 3) begin
                hold_left = HOLD_CYCLES;
            end
            run_random_phase(PHASE_ITEMS);
            wait_drain();
        end
        calm = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.check_leftover();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== url_percent_decoder.f =====
rtl/upd_pkg.sv
rtl/upd_if.sv
rtl/upd_decode.sv
rtl/url_percent_decoder.sv
sim/tb.sv
